@@ rtl/core/lctc_pkg.sv @@
// ----------------------------------------------------------------------------
// lctc_pkg
// Shared types and constants of the LRU chapter tag cache: the per-cell entry
// record, the control word broadcast along the cell chain, and the codes.
// ----------------------------------------------------------------------------
package lctc_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int ID_W      = 8;
	localparam int CNT_PW    = 9;
	localparam int CH_W      = 64;
	localparam int MISS_W    = 17;
	localparam int LIMIT_W   = 16;

	localparam logic [LIMIT_W-1:0] SKIP_LIMIT_RESET = 16'd20000;
	localparam logic [MISS_W-1:0]  MISS_MAX         = '1;
	localparam logic [CH_W-1:0]    EMPTY_CHAPTER    = '1;

	typedef enum logic [1:0] {
		KIND_PROBE,
		KIND_UPDATE,
		KIND_HIT_RPT,
		KIND_MISS_RPT
	} kind_t;

	typedef enum logic [1:0] {
		KEY_ACTIVE,
		KEY_SKIP,
		KEY_DEAD,
		KEY_OUT
	} key_t;

	typedef enum logic [1:0] {
		REP_NONE,
		REP_DEAD,
		REP_EVICT,
		REP_STALE
	} rep_t;

	typedef enum logic [2:0] {
		M_HOLD,
		M_FRONT,
		M_WRITE,
		M_KEY,
		M_SORT
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_ACT,
		ST_KEY,
		ST_SORT,
		ST_CNT,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [CH_W-1:0]   chap;
		logic              skip;
		logic [MISS_W-1:0] miss;
		key_t              key;
	} rec_t;

	typedef struct packed {
		mode_t             mode;
		logic              phase;
		logic [ID_W-1:0]   pos;
		logic [CNT_PW-1:0] live;
		logic [CH_W-1:0]   oldest;
	} ctrl_t;

endpackage

@@ rtl/core/lru_chapter_tag_cache_unit.sv @@
// ----------------------------------------------------------------------------
// lru_chapter_tag_cache_unit
// Fully associative LRU tag store of chapter numbers built as a chain of
// position cells, with probe, update-with-purge and search report words.
// ----------------------------------------------------------------------------
// One word is worked at a time. A probe or report goes from acceptance to
// result through accept, match across all cells, act and deliver. An
// update that misses keys every cell, runs a stable purge as an odd-even
// transposition sort along the cell chain, SLOTS rounds, then counts and
// fills when the chapter is valid. No clearing pass after reset.
module lru_chapter_tag_cache_unit #(
	parameter int SLOTS = lctc_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [63:0] chapter,
	input  logic [63:0] oldest_chapter,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [2:0]  slot,
	output logic [1:0]  replaced,
	output logic        skip_flag,
	output logic [3:0]  live_count
);

	localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [CNT_W-1:0]          SLOTS_C = CNT_W'(SLOTS);
	localparam logic [lctc_pkg::ID_W-1:0] LAST_P  = lctc_pkg::ID_W'(SLOTS - 1);

	lctc_pkg::state_t state_q, state_nxt;
	lctc_pkg::rec_t   rec [SLOTS];
	lctc_pkg::ctrl_t  ctrl;
	lctc_pkg::rec_t   bus;
	lctc_pkg::rec_t   sel;
	lctc_pkg::rec_t   last;

	logic [15:0]              limit_q;
	lctc_pkg::kind_t          kind_q;
	logic [63:0]              chap_q;
	logic [63:0]              old_q;
	logic [CNT_W-1:0]         live_q;
	logic [CNT_W-1:0]         rnd_q;
	logic                     hit_q;
	logic [lctc_pkg::ID_W-1:0] pos_q;

	logic                     res_found_q;
	logic [2:0]               res_slot_q;
	lctc_pkg::rep_t           res_rep_q;
	logic                     res_skip_q;

	logic                     out_valid_q;
	logic                     found_q;
	logic [2:0]               slot_q;
	logic [1:0]               replaced_q;
	logic                     skip_q;
	logic [3:0]               live_out_q;

	logic                     hit_c;
	logic [lctc_pkg::ID_W-1:0] pos_c;
	logic [CNT_W-1:0]         cnt_c;
	logic [lctc_pkg::MISS_W-1:0] miss_inc;
	logic                     deliver;
	logic                     can_fill;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		lctc_cell #(
			.IDX  (i),
			.LAST (SLOTS - 1)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   (rec[(i + SLOTS - 1) % SLOTS]),
			.right  (rec[(i + 1) % SLOTS]),
			.bus    (bus),
			.rec    (rec[i])
		);
	end

	assign sel  = rec[pos_q[IW-1:0]];
	assign last = rec[SLOTS-1];
	assign in_ready = (state_q == lctc_pkg::ST_IDLE);
	assign deliver  = (state_q == lctc_pkg::ST_DONE) && (!out_valid_q || out_ready);
	assign can_fill = (chap_q != lctc_pkg::EMPTY_CHAPTER) && (chap_q >= old_q);
	assign miss_inc = (sel.miss == lctc_pkg::MISS_MAX) ? sel.miss : sel.miss + 1'b1;

	always_comb begin
		hit_c = 1'b0;
		pos_c = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < live_q) && (rec[i].chap == chap_q)
					&& (chap_q != lctc_pkg::EMPTY_CHAPTER)) begin
				hit_c = 1'b1;
				pos_c = lctc_pkg::ID_W'(i);
			end
		end
	end

	always_comb begin
		cnt_c = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if ((rec[i].key == lctc_pkg::KEY_ACTIVE) || (rec[i].key == lctc_pkg::KEY_SKIP)) begin
				cnt_c = cnt_c + 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt   = state_q;
		ctrl.mode   = lctc_pkg::M_HOLD;
		ctrl.phase  = rnd_q[0];
		ctrl.pos    = pos_q;
		ctrl.live   = lctc_pkg::CNT_PW'(live_q);
		ctrl.oldest = old_q;
		bus         = sel;
		unique case (state_q)
			lctc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = lctc_pkg::ST_FIND;
				end
			end
			lctc_pkg::ST_FIND: begin
				state_nxt = lctc_pkg::ST_ACT;
			end
			lctc_pkg::ST_ACT: begin
				state_nxt = lctc_pkg::ST_DONE;
				if (hit_q) begin
					unique case (kind_q)
						lctc_pkg::KIND_PROBE, lctc_pkg::KIND_UPDATE: begin
							ctrl.mode = lctc_pkg::M_FRONT;
							bus.skip  = 1'b0;
						end
						lctc_pkg::KIND_HIT_RPT: begin
							if (sel.chap >= old_q) begin
								ctrl.mode = lctc_pkg::M_FRONT;
								bus.skip  = 1'b0;
								bus.miss  = '0;
							end
						end
						lctc_pkg::KIND_MISS_RPT: begin
							ctrl.mode = lctc_pkg::M_WRITE;
							bus.miss  = miss_inc;
							bus.skip  = sel.skip | (miss_inc > {1'b0, limit_q});
						end
						default: begin
						end
					endcase
				end else if (kind_q == lctc_pkg::KIND_UPDATE) begin
					state_nxt = lctc_pkg::ST_KEY;
				end
			end
			lctc_pkg::ST_KEY: begin
				ctrl.mode = lctc_pkg::M_KEY;
				state_nxt = lctc_pkg::ST_SORT;
			end
			lctc_pkg::ST_SORT: begin
				ctrl.mode = lctc_pkg::M_SORT;
				if (rnd_q == SLOTS_C - 1'b1) begin
					state_nxt = lctc_pkg::ST_CNT;
				end
			end
			lctc_pkg::ST_CNT: begin
				state_nxt = can_fill ? lctc_pkg::ST_FILL : lctc_pkg::ST_DONE;
			end
			lctc_pkg::ST_FILL: begin
				ctrl.mode = lctc_pkg::M_FRONT;
				ctrl.pos  = LAST_P;
				bus       = last;
				bus.chap  = chap_q;
				bus.skip  = 1'b0;
				bus.miss  = '0;
				state_nxt = lctc_pkg::ST_DONE;
			end
			lctc_pkg::ST_DONE: begin
				if (deliver) begin
					state_nxt = lctc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = lctc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lctc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lctc_pkg::SKIP_LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			rnd_q  <= '0;
			hit_q  <= 1'b0;
		end else begin
			unique case (state_q)
				lctc_pkg::ST_FIND: begin
					hit_q <= hit_c;
				end
				lctc_pkg::ST_KEY: begin
					rnd_q <= '0;
				end
				lctc_pkg::ST_SORT: begin
					rnd_q <= rnd_q + 1'b1;
				end
				lctc_pkg::ST_CNT: begin
					live_q <= cnt_c;
				end
				lctc_pkg::ST_FILL: begin
					if (live_q != SLOTS_C) begin
						live_q <= live_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= lctc_pkg::kind_t'(kind);
			chap_q <= chapter;
			old_q  <= oldest_chapter;
		end
		if (state_q == lctc_pkg::ST_FIND) begin
			pos_q <= pos_c;
		end
		if (state_q == lctc_pkg::ST_ACT) begin
			res_found_q <= hit_q;
			res_slot_q  <= hit_q ? sel.id[2:0] : 3'd0;
			res_rep_q   <= lctc_pkg::REP_NONE;
			res_skip_q  <= 1'b0;
			if (hit_q && (kind_q == lctc_pkg::KIND_HIT_RPT) && (sel.chap < old_q)) begin
				res_skip_q <= sel.skip;
			end
			if (hit_q && (kind_q == lctc_pkg::KIND_MISS_RPT)) begin
				res_skip_q <= sel.skip | (miss_inc > {1'b0, limit_q});
			end
		end
		if (state_q == lctc_pkg::ST_FILL) begin
			res_slot_q <= last.id[2:0];
			if (last.chap == lctc_pkg::EMPTY_CHAPTER) begin
				res_rep_q <= lctc_pkg::REP_DEAD;
			end else if (last.chap < old_q) begin
				res_rep_q <= lctc_pkg::REP_STALE;
			end else begin
				res_rep_q <= lctc_pkg::REP_EVICT;
			end
		end
		if (deliver) begin
			found_q    <= res_found_q;
			slot_q     <= res_slot_q;
			replaced_q <= res_rep_q;
			skip_q     <= res_skip_q;
			live_out_q <= 4'(live_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deliver) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign slot       = slot_q;
	assign replaced   = replaced_q;
	assign skip_flag  = skip_q;
	assign live_count = live_out_q;

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= SLOTS_C)
		else $error("live count above slot count");

	a_sort_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lctc_pkg::ST_SORT) |-> (rnd_q < SLOTS_C))
		else $error("purge sort ran past its rounds");

	a_hit_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lctc_pkg::ST_ACT && hit_q) |-> (sel.chap == chap_q))
		else $error("hit position does not hold the chapter");

	a_fill_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lctc_pkg::ST_FILL) |=> (state_q == lctc_pkg::ST_DONE))
		else $error("fill did not go to delivery");

endmodule

@@ rtl/core/lctc_cell.sv @@
// ----------------------------------------------------------------------------
// lctc_cell
// One search position: holds an entry record and trades it with its
// neighbors for move-to-front, in-place writes, purge keying and odd-even sorting.
// ----------------------------------------------------------------------------
module lctc_cell #(
	parameter int IDX  = 0,
	parameter int LAST = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lctc_pkg::ctrl_t ctrl,
	input  lctc_pkg::rec_t  left,
	input  lctc_pkg::rec_t  right,
	input  lctc_pkg::rec_t  bus,
	output lctc_pkg::rec_t  rec
);

	localparam logic PAR       = 1'(IDX % 2);
	localparam logic HAS_RIGHT = (IDX < LAST);
	localparam logic HAS_LEFT  = (IDX > 0);
	localparam logic [lctc_pkg::ID_W-1:0]   MY_POS = lctc_pkg::ID_W'(IDX);
	localparam logic [lctc_pkg::CNT_PW-1:0] MY_CNT = lctc_pkg::CNT_PW'(IDX);

	lctc_pkg::rec_t rec_q;
	lctc_pkg::rec_t nxt;
	logic           dead;

	assign rec  = rec_q;
	assign dead = (rec_q.chap < ctrl.oldest) || (rec_q.chap == lctc_pkg::EMPTY_CHAPTER);

	always_comb begin
		nxt = rec_q;
		unique case (ctrl.mode)
			lctc_pkg::M_HOLD: begin
			end
			lctc_pkg::M_FRONT: begin
				if (IDX == 0) begin
					nxt = bus;
				end else if (MY_POS <= ctrl.pos) begin
					nxt = left;
				end
			end
			lctc_pkg::M_WRITE: begin
				if (MY_POS == ctrl.pos) begin
					nxt = bus;
				end
			end
			lctc_pkg::M_KEY: begin
				if (MY_CNT >= ctrl.live) begin
					nxt.key = lctc_pkg::KEY_OUT;
				end else if (dead) begin
					nxt.key = lctc_pkg::KEY_DEAD;
				end else if (rec_q.skip) begin
					nxt.key = lctc_pkg::KEY_SKIP;
				end else begin
					nxt.key = lctc_pkg::KEY_ACTIVE;
				end
			end
			lctc_pkg::M_SORT: begin
				if (PAR == ctrl.phase) begin
					if (HAS_RIGHT && (rec_q.key > right.key)) begin
						nxt = right;
					end
				end else begin
					if (HAS_LEFT && (left.key > rec_q.key)) begin
						nxt = left;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q.id   <= lctc_pkg::ID_W'(IDX);
			rec_q.chap <= lctc_pkg::EMPTY_CHAPTER;
			rec_q.skip <= 1'b0;
			rec_q.miss <= '0;
			rec_q.key  <= lctc_pkg::KEY_OUT;
		end else begin
			rec_q <= nxt;
		end
	end

endmodule
